[hw/rtl/tpims_pkg.sv]
`default_nettype none
package tpims_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 25;
  localparam int MASS_W = 25;
  localparam logic [MASS_W-1:0] MASS_MAX = 25'h1FFFFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MASS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MASS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PT_MIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PIXEL_HITS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_SIGN_POS = 3'd6;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_FIRST_FAILS = 2'd1;
  localparam logic [1:0] STATUS_SECOND_FAILS = 2'd2;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd3;

  typedef struct packed {
    logic [15:0] first_mass;
    logic [15:0] second_mass;
    logic [24:0] mass_window_low;
    logic [24:0] mass_window_high;
    logic [15:0] pt_min;
    logic [3:0] min_pixel_hits;
    logic second_sign_positive;
  } cfg_t;

  typedef struct packed {
    logic first_ok;
    logic second_ok;
    logic signed [3:0] charge;
  } pair_tag_t;

endpackage
`default_nettype wire

[hw/rtl/tpims_sqrt.sv]
`default_nettype none
module tpims_sqrt #(
  parameter int K = 8,
  parameter int SW = 1
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic en,
  input wire logic in_valid,
  input wire logic [2*K-1:0] radicand,
  input wire logic [SW-1:0] side_in,
  output logic out_valid,
  output logic [K-1:0] root,
  output logic [K+1:0] rem,
  output logic [SW-1:0] side_out
);

  logic v_a [K+1];
  logic [K-1:0] root_a [K+1];
  logic [K+1:0] rem_a [K+1];
  logic [2*K-1:0] rad_a [K+1];
  logic [SW-1:0] side_a [K+1];

  assign v_a[0] = in_valid;
  assign root_a[0] = '0;
  assign rem_a[0] = '0;
  assign rad_a[0] = radicand;
  assign side_a[0] = side_in;

  for (genvar i = 0; i < K; i++) begin : g_stage
    logic [K+1:0] rem_sh;
    logic [K+1:0] trial;
    logic [K+1:0] rem_sub;
    logic take;

    always_comb begin
      rem_sh = {rem_a[i][K-1:0], rad_a[i][2*K-1 -: 2]};
      trial = {root_a[i], 2'b01};
      rem_sub = rem_sh - trial;
      take = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[i+1] <= 1'b0;
      end else if (en) begin
        v_a[i+1] <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_a[i+1] <= {root_a[i][K-2:0], take};
        rem_a[i+1] <= take ? rem_sub : rem_sh;
        rad_a[i+1] <= {rad_a[i][2*K-3:0], 2'b00};
        side_a[i+1] <= side_a[i];
      end
    end
  end

  assign out_valid = v_a[K];
  assign root = root_a[K];
  assign rem = rem_a[K];
  assign side_out = side_a[K];

endmodule
`default_nettype wire

[hw/rtl/tpims_front.sv]
`default_nettype none
module tpims_front
  import tpims_pkg::*;
#(
  parameter int W = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic en,
  input wire logic in_valid,
  input wire cfg_t cfg,
  input wire logic signed [W-1:0] first_px,
  input wire logic signed [W-1:0] first_py,
  input wire logic signed [W-1:0] first_pz,
  input wire logic signed [W-1:0] second_px,
  input wire logic signed [W-1:0] second_py,
  input wire logic signed [W-1:0] second_pz,
  input wire logic signed [2:0] first_charge,
  input wire logic signed [2:0] second_charge,
  input wire logic [3:0] first_pixel_hits,
  input wire logic [3:0] second_pixel_hits,
  input wire logic first_good,
  input wire logic second_good,
  output logic out_valid,
  output logic [2*(2*W+1)-1:0] prod,
  output logic signed [2*W:0] dot,
  output pair_tag_t tag,
  output logic [32:0] msq
);

  localparam int AW = 2 * W + 1;
  localparam int H = (AW + 1) / 2;
  localparam int HH = AW - H;
  localparam int PW = 2 * AW;

  logic [31:0] m1sq, m2sq, ptsq;

  always_ff @(posedge clk) begin
    m1sq <= 32'(cfg.first_mass) * 32'(cfg.first_mass);
    m2sq <= 32'(cfg.second_mass) * 32'(cfg.second_mass);
    ptsq <= 32'(cfg.pt_min) * 32'(cfg.pt_min);
    msq <= 33'(m1sq) + 33'(m2sq);
  end

  // stage 1: squares, dot terms, track flags
  logic signed [2*W-1:0] p1x2, p1y2, p1z2, p2x2, p2y2, p2z2, dxc, dyc, dzc;
  logic chk1_c, chk2_c;

  always_comb begin
    p1x2 = (2*W)'(first_px) * (2*W)'(first_px);
    p1y2 = (2*W)'(first_py) * (2*W)'(first_py);
    p1z2 = (2*W)'(first_pz) * (2*W)'(first_pz);
    p2x2 = (2*W)'(second_px) * (2*W)'(second_px);
    p2y2 = (2*W)'(second_py) * (2*W)'(second_py);
    p2z2 = (2*W)'(second_pz) * (2*W)'(second_pz);
    dxc = (2*W)'(first_px) * (2*W)'(second_px);
    dyc = (2*W)'(first_py) * (2*W)'(second_py);
    dzc = (2*W)'(first_pz) * (2*W)'(second_pz);
    chk1_c = first_good && (first_pixel_hits >= cfg.min_pixel_hits) && (first_charge > 3'sd0);
    chk2_c = second_good && (second_pixel_hits >= cfg.min_pixel_hits) &&
             (cfg.second_sign_positive ? (second_charge > 3'sd0) : (second_charge < 3'sd0));
  end

  logic v1;
  logic [2*W-2:0] s1x, s1y, s1z, s2x, s2y, s2z;
  logic signed [2*W-1:0] d1x, d1y, d1z;
  logic chk1, chk2;
  logic signed [3:0] q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1x <= p1x2[2*W-2:0];
      s1y <= p1y2[2*W-2:0];
      s1z <= p1z2[2*W-2:0];
      s2x <= p2x2[2*W-2:0];
      s2y <= p2y2[2*W-2:0];
      s2z <= p2z2[2*W-2:0];
      d1x <= dxc;
      d1y <= dyc;
      d1z <= dzc;
      chk1 <= chk1_c;
      chk2 <= chk2_c;
      q1 <= 4'(first_charge) + 4'(second_charge);
    end
  end

  // stage 2: energies squared, dot product, pt cut
  logic v2;
  logic [AW-1:0] a1, a2;
  logic signed [AW-1:0] d2;
  pair_tag_t t2;
  logic [2*W-1:0] pt1, pt2;

  always_comb begin
    pt1 = (2*W)'(s1x) + (2*W)'(s1y);
    pt2 = (2*W)'(s2x) + (2*W)'(s2y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= AW'(m1sq) + AW'(s1x) + AW'(s1y) + AW'(s1z);
      a2 <= AW'(m2sq) + AW'(s2x) + AW'(s2y) + AW'(s2z);
      d2 <= AW'(d1x) + AW'(d1y) + AW'(d1z);
      t2.first_ok <= chk1 && (pt1 >= (2*W)'(ptsq));
      t2.second_ok <= chk2 && (pt2 >= (2*W)'(ptsq));
      t2.charge <= q1;
    end
  end

  // stage 3: partial products of a1*a2
  logic v3;
  logic [2*H-1:0] pp_ll;
  logic [AW-1:0] pp_lh, pp_hl;
  logic [2*HH-1:0] pp_hh;
  logic signed [AW-1:0] d3;
  pair_tag_t t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (2*H)'(a1[H-1:0]) * (2*H)'(a2[H-1:0]);
      pp_lh <= AW'(a1[H-1:0]) * AW'(a2[AW-1:H]);
      pp_hl <= AW'(a1[AW-1:H]) * AW'(a2[H-1:0]);
      pp_hh <= (2*HH)'(a1[AW-1:H]) * (2*HH)'(a2[AW-1:H]);
      d3 <= d2;
      t3 <= t2;
    end
  end

  // stage 4: partial product sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (PW'(pp_hh) << (2*H)) + ((PW'(pp_lh) + PW'(pp_hl)) << H) + PW'(pp_ll);
      dot <= d3;
      tag <= t3;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/track_pair_invariant_mass_select.sv]
// throughput: one pair per cycle while the output is not stalled, set by the fully pipelined square-root units
// one result bit of each square root is resolved per pipeline stage
// a stalled output holds the whole pipeline, nothing is dropped
// rst is synchronous active high: clears valid bits and loads register defaults
`default_nettype none
module track_pair_invariant_mass_select
  import tpims_pkg::*;
#(
  parameter int MOMENTUM_WIDTH = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [CFG_INDEX_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // first_px, first_py, first_pz, second_px, second_py, second_pz, first_charge,
  // second_charge, first_pixel_hits, second_pixel_hits, first_good, second_good
  input wire logic [((6*MOMENTUM_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  // pair_mass, pair_charge, status
  output logic [31:0] m_axis_tdata
);

  localparam int W = MOMENTUM_WIDTH;
  localparam int AW = 2 * W + 1;
  localparam int K2 = (AW + 3) / 2;
  localparam int MW = AW + 4;
  localparam int TW = $bits(pair_tag_t);
  localparam int CW = (K2 + 1 > MASS_W) ? K2 + 1 : MASS_W;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_mass <= 16'd494;
      cfg.second_mass <= 16'd494;
      cfg.mass_window_low <= '0;
      cfg.mass_window_high <= MASS_MAX;
      cfg.pt_min <= 16'd700;
      cfg.min_pixel_hits <= 4'd3;
      cfg.second_sign_positive <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_MASS: cfg.first_mass <= cfg_data[15:0];
        REG_SECOND_MASS: cfg.second_mass <= cfg_data[15:0];
        REG_WINDOW_LOW: cfg.mass_window_low <= cfg_data;
        REG_WINDOW_HIGH: cfg.mass_window_high <= cfg_data;
        REG_PT_MIN: cfg.pt_min <= cfg_data[15:0];
        REG_MIN_PIXEL_HITS: cfg.min_pixel_hits <= cfg_data[3:0];
        REG_SECOND_SIGN_POS: cfg.second_sign_positive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic f_valid;
  logic [2*AW-1:0] f_prod;
  logic signed [AW-1:0] f_dot;
  pair_tag_t f_tag;
  logic [32:0] msq;

  tpims_front #(.W(W)) u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s_axis_tvalid),
    .cfg(cfg),
    .first_px(s_axis_tdata[W-1:0]),
    .first_py(s_axis_tdata[2*W-1:W]),
    .first_pz(s_axis_tdata[3*W-1:2*W]),
    .second_px(s_axis_tdata[4*W-1:3*W]),
    .second_py(s_axis_tdata[5*W-1:4*W]),
    .second_pz(s_axis_tdata[6*W-1:5*W]),
    .first_charge(s_axis_tdata[6*W+2:6*W]),
    .second_charge(s_axis_tdata[6*W+5:6*W+3]),
    .first_pixel_hits(s_axis_tdata[6*W+9:6*W+6]),
    .second_pixel_hits(s_axis_tdata[6*W+13:6*W+10]),
    .first_good(s_axis_tdata[6*W+14]),
    .second_good(s_axis_tdata[6*W+15]),
    .out_valid(f_valid),
    .prod(f_prod),
    .dot(f_dot),
    .tag(f_tag),
    .msq(msq)
  );

  logic s1_valid;
  logic [AW-1:0] s1_root;
  logic [AW+TW-1:0] s1_side;

  tpims_sqrt #(.K(AW), .SW(AW + TW)) u_sqrt_energy (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(f_valid),
    .radicand(f_prod),
    .side_in({f_dot, f_tag}),
    .out_valid(s1_valid),
    .root(s1_root),
    .rem(),
    .side_out(s1_side)
  );

  // mass squared, negative clamped to zero
  logic [MW-1:0] m2s;
  logic m2_valid;
  logic [2*K2-1:0] m2;
  pair_tag_t m2_tag;

  always_comb begin
    m2s = MW'(msq) + (MW'(s1_root) << 1) - (MW'($signed(s1_side[AW+TW-1:TW])) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= m2s[MW-1] ? '0 : m2s[2*K2-1:0];
      m2_tag <= s1_side[TW-1:0];
    end
  end

  logic s2_valid;
  logic [K2-1:0] s2_root;
  logic [K2+1:0] s2_rem;
  logic [TW-1:0] s2_side;

  tpims_sqrt #(.K(K2), .SW(TW)) u_sqrt_mass (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(m2_valid),
    .radicand(m2),
    .side_in(m2_tag),
    .out_valid(s2_valid),
    .root(s2_root),
    .rem(s2_rem),
    .side_out(s2_side)
  );

  // round to nearest
  logic r_valid;
  logic [CW-1:0] r_mass;
  pair_tag_t r_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_mass <= CW'(s2_root) + CW'(s2_rem > (K2 + 2)'(s2_root));
      r_tag <= s2_side;
    end
  end

  // window check and output register
  logic [MASS_W-1:0] out_mass;
  logic signed [3:0] out_charge;
  logic [1:0] out_status;
  logic [1:0] status_c;

  always_comb begin
    if (!r_tag.first_ok) begin
      status_c = STATUS_FIRST_FAILS;
    end else if (!r_tag.second_ok) begin
      status_c = STATUS_SECOND_FAILS;
    end else if (!(r_mass > CW'(cfg.mass_window_low) && r_mass < CW'(cfg.mass_window_high))) begin
      status_c = STATUS_OUTSIDE;
    end else begin
      status_c = STATUS_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mass <= (r_mass > CW'(MASS_MAX)) ? MASS_MAX : r_mass[MASS_W-1:0];
      out_charge <= r_tag.charge;
      out_status <= status_c;
    end
  end

  assign m_axis_tdata = {1'b0, out_status, out_charge, out_mass};

endmodule
`default_nettype wire

[hw/rtl/tpims_checker.sv]
`default_nettype none
module tpims_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output stall");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("padding bit set");

endmodule

bind track_pair_invariant_mass_select tpims_checker u_tpims_checker (.*);
`default_nettype wire
